// ----- src/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned OpW    = 3;
  localparam int unsigned PosW   = 5;
  localparam int unsigned StatW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_INSERT   = 3'd0,
    OP_APPEND   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_DEL_LAST = 3'd3,
    OP_TRAVERSE = 3'd4
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_END   = 3'd4
  } status_t;

  // What every cell of the chain does in a given cycle.
  typedef enum logic [1:0] {
    CK_HOLD   = 2'd0,
    CK_INSERT = 2'd1,
    CK_DELETE = 2'd2,
    CK_ROTATE = 2'd3
  } cell_kind_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_TRAV = 1'b1
  } state_t;

endpackage
`default_nettype wire

// ----- src/ple_cell.sv -----
// One slot of the list chain; picks its next value from itself, a neighbor, the new value or the head cell.
`timescale 1ns / 1ps
`default_nettype none
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4
) (
  input  wire logic                     clk,
  input  wire cell_kind_t               kind,
  input  wire logic [IW-1:0]            pos,       // insert/delete position
  input  wire logic [IW-1:0]            last_idx,  // index of last stored value
  input  wire logic signed [ValueW-1:0] new_value,
  input  wire logic signed [ValueW-1:0] left_data,
  input  wire logic signed [ValueW-1:0] right_data,
  input  wire logic signed [ValueW-1:0] head_data,
  output logic signed [ValueW-1:0]      data_q
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic signed [ValueW-1:0] slot_r;
  logic signed [ValueW-1:0] slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    case (kind)
      CK_INSERT: begin
        if (MyIdx == pos) begin
          slot_nxt = new_value;
        end else if (MyIdx > pos) begin
          slot_nxt = left_data;
        end
      end
      CK_DELETE: begin
        if (MyIdx >= pos) begin
          slot_nxt = right_data;
        end
      end
      CK_ROTATE: begin
        // Head wraps around to the tail so the list is restored after a full pass.
        if (MyIdx == last_idx) begin
          slot_nxt = head_data;
        end else if (MyIdx < last_idx) begin
          slot_nxt = right_data;
        end
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign data_q = slot_r;

endmodule
`default_nettype wire

// ----- src/positional_list_engine_core.sv -----
// Positional list engine: chain of value cells plus command control and output register.
// A non-traverse command gives its single result, registered, in the cycle after acceptance.
// Traverse: acceptance enters the traverse state, which then gives one value per cycle while
// the output is free, as the cell chain rotates; the next command is taken once the last
// value is registered. Other commands: one per cycle while the output is free.
// Reset clears the length, control state and output valid; slot contents are left as is.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // operation[2:0], new_value[34:3], position[39:35]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // value[31:0]
  output logic [2:0]       out_tuser,  // status[2:0]
  output logic             out_tlast
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = (LW > PosW) ? LW : PosW;

  // Input fields
  op_t                      in_op;
  logic signed [ValueW-1:0] in_val;
  logic [PosW-1:0]          in_pos;
  logic [CW-1:0]            pos_ext;
  logic [CW-1:0]            len_ext;

  assign in_op   = op_t'(in_tdata[2:0]);
  assign in_val  = in_tdata[34:3];
  assign in_pos  = in_tdata[39:35];
  assign pos_ext = CW'(in_pos);

  state_t                   state_r, state_nxt;
  logic [LW-1:0]            len_r, len_nxt;
  logic [IW-1:0]            cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [ValueW-1:0] out_value_r, out_value_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     out_free;
  logic                     full;
  logic [LW-1:0]            len_m1;
  cell_kind_t               cell_kind;
  logic [IW-1:0]            cell_pos;
  logic signed [ValueW-1:0] cell_data [CAPACITY];

  assign len_ext  = CW'(len_r);
  assign out_free = !out_valid_r || out_tready;
  assign full     = (len_r == LW'(CAPACITY));
  assign len_m1   = len_r - LW'(1);

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    cell_kind      = CK_HOLD;
    cell_pos       = '0;
    in_tready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = out_free;
        if (in_tvalid && out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_OK;
          case (in_op)
            OP_INSERT, OP_APPEND: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cell_kind = CK_INSERT;
                len_nxt   = len_r + LW'(1);
                if (in_op == OP_APPEND || pos_ext >= len_ext) begin
                  cell_pos = len_r[IW-1:0];
                  if (in_op == OP_INSERT && pos_ext > len_ext) begin
                    out_status_nxt = ST_END;
                  end
                end else begin
                  cell_pos = pos_ext[IW-1:0];
                end
              end
            end
            OP_DELETE: begin
              if (len_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (pos_ext >= len_ext) begin
                out_status_nxt = ST_RANGE;
              end else begin
                cell_kind = CK_DELETE;
                cell_pos  = pos_ext[IW-1:0];
                len_nxt   = len_m1;
              end
            end
            OP_DEL_LAST: begin
              if (len_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                cell_kind = CK_DELETE;
                cell_pos  = len_m1[IW-1:0];
                len_nxt   = len_m1;
              end
            end
            OP_TRAVERSE: begin
              if (len_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // values come out of the head cell in the following cycles
                out_valid_nxt = 1'b0;
                cnt_nxt       = '0;
                state_nxt     = S_TRAV;
              end
            end
            default: begin
              out_status_nxt = ST_RANGE;
            end
          endcase
        end
      end
      S_TRAV: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = cell_data[0];
          out_status_nxt = ST_OK;
          out_last_nxt   = (LW'(cnt_r) == len_m1);
          cell_kind      = CK_ROTATE;
          cnt_nxt        = cnt_r + IW'(1);
          if (LW'(cnt_r) == len_m1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Cell chain: left neighbor feeds inserts, right neighbor feeds deletes and rotation.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [ValueW-1:0] left_d;
    logic signed [ValueW-1:0] right_d;
    if (k == 0) begin : g_first
      assign left_d = in_val;
    end else begin : g_mid_l
      assign left_d = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_end
      assign right_d = cell_data[k];
    end else begin : g_mid_r
      assign right_d = cell_data[k+1];
    end
    ple_cell #(
      .IDX (k),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .kind       (cell_kind),
      .pos        (cell_pos),
      .last_idx   (len_m1[IW-1:0]),
      .new_value  (in_val),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data_q     (cell_data[k])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  a_trav_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRAV) |-> (len_r != '0))
    else $error("traversal running on empty list");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op != OP_TRAVERSE) |=> (out_tvalid && out_tlast))
    else $error("command result missing");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op == OP_APPEND && !full)
      |=> (len_r == $past(len_r) + LW'(1)))
    else $error("append did not grow the list");

endmodule
`default_nettype wire
